### sv/csclip_pkg.sv
package csclip_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_WIDTH = 4;
  localparam int MAX_CLIPS = 4;
  localparam int CLIP_COUNT_WIDTH = $clog2(MAX_CLIPS + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [COORD_WIDTH:0] diff_t;
  typedef logic [3:0] outcode_t;

  localparam outcode_t OC_TOP = 4'h1;
  localparam outcode_t OC_BOTTOM = 4'h2;
  localparam outcode_t OC_RIGHT = 4'h4;
  localparam outcode_t OC_LEFT = 4'h8;

  localparam coord_t X_MIN_RESET = coord_t'(0);
  localparam coord_t Y_MIN_RESET = coord_t'(0);
  localparam coord_t X_MAX_RESET = coord_t'(639);
  localparam coord_t Y_MAX_RESET = coord_t'(479);

  typedef enum logic [1:0] {
    REG_X_MIN = 2'd0,
    REG_Y_MIN = 2'd1,
    REG_X_MAX = 2'd2,
    REG_Y_MAX = 2'd3
  } reg_index_t;

  typedef struct packed {
    coord_t x_min;
    coord_t y_min;
    coord_t x_max;
    coord_t y_max;
  } window_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
  } request_t;

  typedef struct packed {
    logic   accepted;
    coord_t clipped_start_x;
    coord_t clipped_start_y;
    coord_t clipped_end_x;
    coord_t clipped_end_y;
  } result_t;

  typedef struct packed {
    logic   valid;
    coord_t base;
    diff_t  span;
    diff_t  num;
    diff_t  den;
  } isect_req_t;

  typedef struct packed {
    logic   done;
    coord_t value;
  } isect_rsp_t;

  function automatic outcode_t outcode(input coord_t x, input coord_t y, input window_t w);
    outcode_t c;
    c = '0;
    if (y > w.y_max) begin
      c = c | OC_TOP;
    end else if (y < w.y_min) begin
      c = c | OC_BOTTOM;
    end
    if (x > w.x_max) begin
      c = c | OC_RIGHT;
    end else if (x < w.x_min) begin
      c = c | OC_LEFT;
    end
    return c;
  endfunction

endpackage

### sv/csclip_cfg.sv
module csclip_cfg
  import csclip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output window_t               window
);

  reg_index_t index;
  coord_t     read_value;

  assign index = reg_index_t'(paddr[3:2]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window.x_min <= X_MIN_RESET;
      window.y_min <= Y_MIN_RESET;
      window.x_max <= X_MAX_RESET;
      window.y_max <= Y_MAX_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (index)
        REG_X_MIN: window.x_min <= coord_t'(pwdata[COORD_WIDTH-1:0]);
        REG_Y_MIN: window.y_min <= coord_t'(pwdata[COORD_WIDTH-1:0]);
        REG_X_MAX: window.x_max <= coord_t'(pwdata[COORD_WIDTH-1:0]);
        REG_Y_MAX: window.y_max <= coord_t'(pwdata[COORD_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (index)
      REG_X_MIN: read_value = window.x_min;
      REG_Y_MIN: read_value = window.y_min;
      REG_X_MAX: read_value = window.x_max;
      REG_Y_MAX: read_value = window.y_max;
      default:   read_value = '0;
    endcase
  end

  assign prdata = {{(DATA_WIDTH-COORD_WIDTH){1'b0}}, read_value};

endmodule

### sv/csclip_isect.sv
module csclip_isect
  import csclip_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  isect_req_t req,
  output isect_rsp_t rsp
);

  localparam int W = COORD_WIDTH;
  localparam int STEP_WIDTH = $clog2(2 * W);
  localparam logic [STEP_WIDTH-1:0] STEP_LAST = STEP_WIDTH'(2 * W - 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_FIN} state_t;

  state_t                state;
  coord_t                base;
  logic [W-1:0]          mag_a;
  logic [W-1:0]          mag_b;
  logic [W-1:0]          divisor;
  logic                  neg;
  logic [2*W-1:0]        dividend;
  logic [W-1:0]          rem;
  logic [W-1:0]          quo;
  logic [STEP_WIDTH-1:0] step;
  logic                  done;
  coord_t                value;

  logic [2*W-1:0] product;
  logic [W:0]     rem_shift;
  logic [W:0]     rem_diff;
  logic           fits;
  logic [W-1:0]   quo_signed;

  function automatic logic [W-1:0] mag(input diff_t v);
    diff_t n;
    n = v[W] ? -v : v;
    return n[W-1:0];
  endfunction

  assign product = mag_a * mag_b;
  assign rem_shift = {rem, dividend[2*W-1]};
  assign rem_diff = rem_shift - {1'b0, divisor};
  assign fits = rem_shift >= {1'b0, divisor};
  assign quo_signed = neg ? -quo : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            base <= req.base;
            mag_a <= mag(req.span);
            mag_b <= mag(req.num);
            divisor <= mag(req.den);
            neg <= req.span[W] ^ req.num[W] ^ req.den[W];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          dividend <= product;
          rem <= '0;
          quo <= '0;
          step <= '0;
          state <= (divisor == '0) ? S_FIN : S_DIV;
        end
        S_DIV: begin
          dividend <= {dividend[2*W-2:0], 1'b0};
          rem <= fits ? rem_diff[W-1:0] : rem_shift[W-1:0];
          quo <= {quo[W-2:0], fits};
          step <= step + 1'b1;
          if (step == STEP_LAST) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          value <= base + coord_t'(quo_signed);
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.value = value;

endmodule

### sv/cohen_sutherland_line_clipper.sv
// Cohen-Sutherland line clipper.
// Request channel: drive a segment on request and raise start; it is taken
// at a rising edge where start is high and busy is low. busy stays high
// until the result is shown.
// Result channel: done is high for exactly one cycle with result valid in
// that cycle. result.accepted flags a visible segment; a rejected segment
// reports all clipped coordinates as zero. The receiver cannot stall.
// Window: four 16-bit signed registers on the APB port at byte addresses
// 0 (x_min), 4 (y_min), 8 (x_max), 12 (y_max); write them only while idle.
// Each request makes n edge clips (0 to 4) before its result is shown.
// Each clip runs through one shared intersection unit: operand capture,
// a 16x16 multiply, a 32-step restoring divide at one quotient bit a cycle,
// a final add and handing the point back. One request at a time;
// the next may be issued in the cycle the result is shown.
// Reset: synchronous on rst; the window returns to 0,0 .. 639,479 and the
// block goes idle.
module cohen_sutherland_line_clipper
  import csclip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  request_t              request,
  output logic                  done,
  output result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_WAIT} state_t;

  window_t    window;
  isect_req_t isect_req;
  isect_rsp_t isect_rsp;

  state_t                      state;
  coord_t                      x0;
  coord_t                      y0;
  coord_t                      x1;
  coord_t                      y1;
  logic [CLIP_COUNT_WIDTH-1:0] clips;
  logic                        move_start;
  logic                        fix_y;
  coord_t                      fix_val;

  outcode_t c0;
  outcode_t c1;
  outcode_t co;
  logic     trivial_accept;
  logic     trivial_reject;
  logic     sel_fix_y;
  coord_t   sel_fix_val;

  csclip_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .window  (window)
  );

  csclip_isect u_isect (
    .clk (clk),
    .rst (rst),
    .req (isect_req),
    .rsp (isect_rsp)
  );

  assign c0 = outcode(x0, y0, window);
  assign c1 = outcode(x1, y1, window);
  assign co = (c0 != '0) ? c0 : c1;
  assign trivial_accept = (c0 | c1) == '0;
  assign trivial_reject = ((c0 & c1) != '0) || (clips == CLIP_COUNT_WIDTH'(MAX_CLIPS));

  always_comb begin
    isect_req.valid = (state == ST_EVAL) && !trivial_accept && !trivial_reject;
    priority if ((co & OC_TOP) != '0) begin
      isect_req.base = x0;
      isect_req.span = diff_t'(x1) - diff_t'(x0);
      isect_req.num = diff_t'(window.y_max) - diff_t'(y0);
      isect_req.den = diff_t'(y1) - diff_t'(y0);
      sel_fix_y = 1'b1;
      sel_fix_val = window.y_max;
    end else if ((co & OC_BOTTOM) != '0) begin
      isect_req.base = x0;
      isect_req.span = diff_t'(x1) - diff_t'(x0);
      isect_req.num = diff_t'(window.y_min) - diff_t'(y0);
      isect_req.den = diff_t'(y1) - diff_t'(y0);
      sel_fix_y = 1'b1;
      sel_fix_val = window.y_min;
    end else if ((co & OC_RIGHT) != '0) begin
      isect_req.base = y0;
      isect_req.span = diff_t'(y1) - diff_t'(y0);
      isect_req.num = diff_t'(window.x_max) - diff_t'(x0);
      isect_req.den = diff_t'(x1) - diff_t'(x0);
      sel_fix_y = 1'b0;
      sel_fix_val = window.x_max;
    end else begin
      isect_req.base = y0;
      isect_req.span = diff_t'(y1) - diff_t'(y0);
      isect_req.num = diff_t'(window.x_min) - diff_t'(x0);
      isect_req.den = diff_t'(x1) - diff_t'(x0);
      sel_fix_y = 1'b0;
      sel_fix_val = window.x_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            x0 <= request.start_x;
            y0 <= request.start_y;
            x1 <= request.end_x;
            y1 <= request.end_y;
            clips <= '0;
            busy <= 1'b1;
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (trivial_accept || trivial_reject) begin
            done <= 1'b1;
            result.accepted <= trivial_accept;
            result.clipped_start_x <= trivial_accept ? x0 : '0;
            result.clipped_start_y <= trivial_accept ? y0 : '0;
            result.clipped_end_x <= trivial_accept ? x1 : '0;
            result.clipped_end_y <= trivial_accept ? y1 : '0;
            busy <= 1'b0;
            state <= ST_IDLE;
          end else begin
            move_start <= c0 != '0;
            fix_y <= sel_fix_y;
            fix_val <= sel_fix_val;
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (isect_rsp.done) begin
            if (move_start) begin
              x0 <= fix_y ? isect_rsp.value : fix_val;
              y0 <= fix_y ? fix_val : isect_rsp.value;
            end else begin
              x1 <= fix_y ? isect_rsp.value : fix_val;
              y1 <= fix_y ? fix_val : isect_rsp.value;
            end
            clips <= clips + 1'b1;
            state <= ST_EVAL;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  a_done_when_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  a_busy_ends_with_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy dropped without result");

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.accepted |-> result.clipped_start_x == '0 &&
      result.clipped_start_y == '0 && result.clipped_end_x == '0 &&
      result.clipped_end_y == '0)
    else $error("rejected segment with nonzero coordinates");
`endif

endmodule

### tb/csclip_checker.sv
module csclip_checker
  import csclip_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  request_t              request,
  input  logic                  done,
  input  result_t               result,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output int                    pending,
  output int                    fail_count,
  output int                    visible_count
);

  window_t window;
  result_t clipped_q[$];
  int      errors = 0;
  int      visible = 0;

  function automatic outcode_t region_code(input longint x, input longint y, input window_t w);
    outcode_t c;
    c = '0;
    if (y > longint'(w.y_max)) begin
      c = c | OC_TOP;
    end else if (y < longint'(w.y_min)) begin
      c = c | OC_BOTTOM;
    end
    if (x > longint'(w.x_max)) begin
      c = c | OC_RIGHT;
    end else if (x < longint'(w.x_min)) begin
      c = c | OC_LEFT;
    end
    return c;
  endfunction

  function automatic longint edge_cross(input longint base, input longint span,
                                        input longint num, input longint den);
    longint q;
    if (den == 0) begin
      return longint'(coord_t'(base));
    end
    q = (span * num) / den;
    return longint'(coord_t'(base + q));
  endfunction

  function automatic result_t clip_segment(input request_t seg, input window_t w);
    longint   x0, y0, x1, y1, x, y;
    outcode_t c0, c1, co;
    logic     visible_seg;
    logic     settled;
    result_t  r;
    x0 = longint'(seg.start_x);
    y0 = longint'(seg.start_y);
    x1 = longint'(seg.end_x);
    y1 = longint'(seg.end_y);
    c0 = region_code(x0, y0, w);
    c1 = region_code(x1, y1, w);
    visible_seg = 1'b0;
    settled = 1'b0;
    for (int n = 0; n <= MAX_CLIPS && !settled; n++) begin
      if ((c0 | c1) == '0) begin
        visible_seg = 1'b1;
        settled = 1'b1;
      end else if ((c0 & c1) != '0) begin
        settled = 1'b1;
      end else if (n < MAX_CLIPS) begin
        co = (c0 != '0) ? c0 : c1;
        if ((co & OC_TOP) != '0) begin
          x = edge_cross(x0, x1 - x0, longint'(w.y_max) - y0, y1 - y0);
          y = longint'(w.y_max);
        end else if ((co & OC_BOTTOM) != '0) begin
          x = edge_cross(x0, x1 - x0, longint'(w.y_min) - y0, y1 - y0);
          y = longint'(w.y_min);
        end else if ((co & OC_RIGHT) != '0) begin
          y = edge_cross(y0, y1 - y0, longint'(w.x_max) - x0, x1 - x0);
          x = longint'(w.x_max);
        end else begin
          y = edge_cross(y0, y1 - y0, longint'(w.x_min) - x0, x1 - x0);
          x = longint'(w.x_min);
        end
        if (c0 != '0) begin
          x0 = x;
          y0 = y;
          c0 = region_code(x0, y0, w);
        end else begin
          x1 = x;
          y1 = y;
          c1 = region_code(x1, y1, w);
        end
      end
    end
    r.accepted = visible_seg;
    r.clipped_start_x = visible_seg ? coord_t'(x0) : '0;
    r.clipped_start_y = visible_seg ? coord_t'(y0) : '0;
    r.clipped_end_x = visible_seg ? coord_t'(x1) : '0;
    r.clipped_end_y = visible_seg ? coord_t'(y1) : '0;
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [COORD_WIDTH-1:0] want,
                             input logic signed [COORD_WIDTH-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      window.x_min = X_MIN_RESET;
      window.y_min = Y_MIN_RESET;
      window.x_max = X_MAX_RESET;
      window.y_max = Y_MAX_RESET;
      clipped_q.delete();
    end else begin
      if (done) begin
        if (clipped_q.size() == 0) begin
          $display("%0t: result with no request outstanding: expected none, got %p",
                   $time, result);
          errors++;
        end else begin
          want = clipped_q.pop_front();
          check_field("accepted", COORD_WIDTH'(want.accepted), COORD_WIDTH'(result.accepted));
          check_field("clipped_start_x", want.clipped_start_x, result.clipped_start_x);
          check_field("clipped_start_y", want.clipped_start_y, result.clipped_start_y);
          check_field("clipped_end_x", want.clipped_end_x, result.clipped_end_x);
          check_field("clipped_end_y", want.clipped_end_y, result.clipped_end_y);
          if (result.accepted === 1'b1) begin
            visible++;
          end
        end
      end
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[ADDR_WIDTH-1:2]))
          REG_X_MIN: window.x_min = coord_t'(pwdata[COORD_WIDTH-1:0]);
          REG_Y_MIN: window.y_min = coord_t'(pwdata[COORD_WIDTH-1:0]);
          REG_X_MAX: window.x_max = coord_t'(pwdata[COORD_WIDTH-1:0]);
          REG_Y_MAX: window.y_max = coord_t'(pwdata[COORD_WIDTH-1:0]);
          default: ;
        endcase
      end
      if (start && !busy) begin
        clipped_q.push_back(clip_segment(request, window));
      end
    end
    pending <= clipped_q.size();
    fail_count <= errors;
    visible_count <= visible;
  end

endmodule

### tb/tb_cohen_sutherland_line_clipper.sv
module tb_cohen_sutherland_line_clipper;
  import csclip_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int TAIL_CYCLES = 200;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  request_t              request = '0;
  logic                  done;
  result_t               result;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr = '0;
  logic [DATA_WIDTH-1:0] pwdata = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  int       pending;
  int       fail_count;
  int       visible_count;
  int       cycles = 0;
  int       items_sent = 0;
  int       windows_used = 0;
  int       zero_run = 0;
  request_t directed_segs[$];

  cohen_sutherland_line_clipper u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  csclip_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .request       (request),
    .done          (done),
    .result        (result),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .pending       (pending),
    .fail_count    (fail_count),
    .visible_count (visible_count)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d requests outstanding", cycles, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic request_t make_seg(input int x0, input int y0, input int x1, input int y1);
    request_t s;
    s.start_x = coord_t'(x0);
    s.start_y = coord_t'(y0);
    s.end_x = coord_t'(x1);
    s.end_y = coord_t'(y1);
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    if (zero_run > 0) begin
      zero_run--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 10) begin
      zero_run = $urandom_range(5, 20);
      return 0;
    end else if (r < 40) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic coord_t pick_coord(input coord_t lo, input coord_t hi);
    longint a, b, m, v;
    int     r;
    a = (lo < hi) ? longint'(lo) : longint'(hi);
    b = (lo < hi) ? longint'(hi) : longint'(lo);
    r = $urandom_range(0, 9);
    if (r < 6) begin
      m = (b - a) / 2 + 8;
      v = a - m + longint'($urandom_range(0, int'(b - a + 2 * m)));
      if (v < -32768) v = -32768;
      if (v > 32767) v = 32767;
    end else if (r < 8) begin
      v = longint'(coord_t'($urandom));
    end else if (r < 9) begin
      case ($urandom_range(0, 5))
        0: v = a;
        1: v = b;
        2: v = a - 1;
        3: v = b + 1;
        4: v = a + 1;
        default: v = b - 1;
      endcase
    end else begin
      v = $urandom_range(0, 1) ? 32767 : -32768;
    end
    return coord_t'(v);
  endfunction

  function automatic window_t choose_window(input int kind);
    window_t w;
    coord_t  a, b, c, d;
    a = coord_t'($urandom);
    b = coord_t'($urandom);
    c = coord_t'($urandom);
    d = coord_t'($urandom);
    w.x_min = (a < b) ? a : b;
    w.x_max = (a < b) ? b : a;
    w.y_min = (c < d) ? c : d;
    w.y_max = (c < d) ? d : c;
    case (kind)
      0: begin
        w.x_min = coord_t'(-32768);
        w.y_min = coord_t'(-32768);
        w.x_max = coord_t'(32767);
        w.y_max = coord_t'(32767);
      end
      1: begin
        w.x_max = w.x_min;
        w.y_max = w.y_min;
      end
      3, 6: begin
        w.x_min = (a < b) ? b : a;
        w.x_max = (a < b) ? a : b;
        if (kind == 6) begin
          w.y_min = (c < d) ? d : c;
          w.y_max = (c < d) ? c : d;
        end
      end
      4: begin
        w.x_min = coord_t'(32767 - $urandom_range(0, 800));
        w.x_max = coord_t'(32767);
        w.y_min = coord_t'(-32768);
        w.y_max = coord_t'(-32768 + $urandom_range(0, 800));
      end
      2, 5, 7: ;
      default: begin
        w.x_min = X_MIN_RESET;
        w.y_min = Y_MIN_RESET;
        w.x_max = X_MAX_RESET;
        w.y_max = Y_MAX_RESET;
      end
    endcase
    return w;
  endfunction

  function automatic request_t random_segment(input window_t w);
    request_t s;
    s.start_x = pick_coord(w.x_min, w.x_max);
    s.start_y = pick_coord(w.y_min, w.y_max);
    s.end_x = pick_coord(w.x_min, w.x_max);
    s.end_y = pick_coord(w.y_min, w.y_max);
    return s;
  endfunction

  task automatic issue_segment(input request_t seg);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request <= seg;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input coord_t v);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_WIDTH'({idx, 2'b00});
    pwdata <= {{(DATA_WIDTH-COORD_WIDTH){v[COORD_WIDTH-1]}}, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_window(input window_t w);
    write_reg(REG_X_MIN, w.x_min);
    write_reg(REG_Y_MIN, w.y_min);
    write_reg(REG_X_MAX, w.x_max);
    write_reg(REG_Y_MAX, w.y_max);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    window_t w;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    directed_segs.push_back(make_seg(100, 100, 500, 400));
    directed_segs.push_back(make_seg(0, 0, 639, 479));
    directed_segs.push_back(make_seg(-50, -50, -10, -5));
    directed_segs.push_back(make_seg(700, 10, 800, 400));
    directed_segs.push_back(make_seg(100, -200, 300, 700));
    directed_segs.push_back(make_seg(-300, 240, 900, 240));
    directed_segs.push_back(make_seg(-100, -100, 800, 600));
    directed_segs.push_back(make_seg(320, 240, 320, 900));
    directed_segs.push_back(make_seg(-500, 100, 200, 200));
    directed_segs.push_back(make_seg(-100, 400, 100, 700));
    directed_segs.push_back(make_seg(-32768, -32768, 32767, 32767));
    directed_segs.push_back(make_seg(32767, -32768, -32768, 32767));
    directed_segs.push_back(make_seg(-32768, 0, -32768, 0));
    directed_segs.push_back(make_seg(320, 240, 320, 240));
    directed_segs.push_back(make_seg(32767, 32767, 32767, 32767));
    directed_segs.push_back(make_seg(-1, -1, 640, 480));
    directed_segs.push_back(make_seg(639, -1, 640, 0));
    foreach (directed_segs[i]) begin
      issue_segment(directed_segs[i]);
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      w = choose_window(p);
      program_window(w);
      windows_used++;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        issue_segment(random_segment(w));
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Clipped %0d segments (%0d directed), %0d visible, over %0d programmed windows",
             items_sent, directed_segs.size(), visible_count, windows_used);
    $display("Windows: reset, full range, single point, extreme corner, inverted, random");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
sv/csclip_pkg.sv
sv/csclip_cfg.sv
sv/csclip_isect.sv
sv/cohen_sutherland_line_clipper.sv
tb/csclip_checker.sv
tb/tb_cohen_sutherland_line_clipper.sv
